// ===== hw/rtl/xtea_block_cipher_core_defines.svh =====
// ----------------------------------------------------------------------------
// XTEA block cipher core: assertion macros
// Shared concurrent checks, clocked on the rising edge and off in reset.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_CORE_DEFINES_SVH
`define XTEA_BLOCK_CIPHER_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons holds in that cycle.
`define XTEA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("xtea check failed");

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define XTEA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("xtea check failed");

`endif

// ===== hw/rtl/xtea_pkg.sv =====
// ----------------------------------------------------------------------------
// XTEA package
// Types, cipher constants and the per-stage round sum used by the core.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam logic [31:0] DELTA        = 32'h9E3779B9;
    localparam logic [31:0] DEC_SUM_INIT = 32'hC6EF3720;
    localparam int          CYCLES       = 32;
    localparam int          NUM_STAGES   = 2 * CYCLES;
    localparam int          KEY_WORDS    = 4;
    localparam int          Z_SEL_LSB    = 11;
    localparam int          SHL_AMT      = 4;
    localparam int          SHR_AMT      = 5;

    // Key register indexes on the configuration port
    localparam logic [1:0] KEY_IDX_ZERO  = 2'd0;
    localparam logic [1:0] KEY_IDX_ONE   = 2'd1;
    localparam logic [1:0] KEY_IDX_TWO   = 2'd2;
    localparam logic [1:0] KEY_IDX_THREE = 2'd3;

    // Direction codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef logic [KEY_WORDS-1:0][31:0] key_t;

    typedef struct packed {
        logic        op;
        logic [31:0] y;
        logic [31:0] z;
    } blk_t;

    // Running sum seen by half-round stage, for either direction.
    function automatic logic [31:0] half_sum(input int stage, input logic dec);
        int          k;
        logic [31:0] prod;
        k    = (stage + 1) / 2;
        prod = 32'(k) * DELTA;
        return dec ? (DEC_SUM_INIT - prod) : prod;
    endfunction

endpackage

// ===== hw/rtl/xtea_block_cipher_core.sv =====
// ----------------------------------------------------------------------------
// XTEA block cipher core
// Datapath: one half-round a stage between input accept and result valid.
// Throughput: one 64-bit word per cycle; the 64-stage pipeline advances as one
// and holds whenever the result register is full and not taken.
// Reset: synchronous active-low aresetn clears stage valids and key words to 0.
// ----------------------------------------------------------------------------
`include "xtea_block_cipher_core_defines.svh"

module xtea_block_cipher_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // input word channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_block_first,
    input  logic [31:0] s_block_second,
    // result word channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_first,
    output logic [31:0] m_out_second
);
    import xtea_pkg::*;

    key_t                  key;
    logic                  en;
    logic [NUM_STAGES:0]   vld;
    blk_t [NUM_STAGES:0]   blk;

    assign cfg_ready = 1'b1;

    xtea_key_regs u_key_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key       (key)
    );

    // advance the whole pipe unless the last stage holds an untaken word
    assign en      = !vld[NUM_STAGES] || m_ready;
    assign s_ready = en;

    assign vld[0]    = s_valid;
    assign blk[0].op = s_op;
    assign blk[0].y  = s_block_first;
    assign blk[0].z  = s_block_second;

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
        xtea_round #(
            .STAGE_IDX (i)
        ) u_round (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .key     (key),
            .in_vld  (vld[i]),
            .in_blk  (blk[i]),
            .out_vld (vld[i+1]),
            .out_blk (blk[i+1])
        );
    end

    assign m_valid      = vld[NUM_STAGES];
    assign m_out_first  = blk[NUM_STAGES].y;
    assign m_out_second = blk[NUM_STAGES].z;

    `XTEA_ASSERT_NEXT(a_stall_freezes, aclk, aresetn, !en, $stable(vld[NUM_STAGES:1]))
    `XTEA_ASSERT_NEXT(a_entry_moves, aclk, aresetn, s_valid && s_ready, vld[1])
    `XTEA_ASSERT_NEXT(a_no_phantom, aclk, aresetn, en && !vld[NUM_STAGES-1], !m_valid)
    `XTEA_ASSERT_NEXT(a_key_write, aclk, aresetn,
        cfg_valid && cfg_ready && cfg_index == KEY_IDX_ZERO, key[0] == $past(cfg_data))

endmodule

// ===== hw/rtl/xtea_key_regs.sv =====
// ----------------------------------------------------------------------------
// XTEA key registers
// Four 32-bit key words written through the configuration port.
// ----------------------------------------------------------------------------
module xtea_key_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    output xtea_pkg::key_t   key
);
    import xtea_pkg::*;

    key_t key_reg;
    key_t key_next;

    always_comb begin
        key_next = key_reg;
        if (cfg_valid) begin
            case (cfg_index)
                KEY_IDX_ZERO:  key_next[0] = cfg_data;
                KEY_IDX_ONE:   key_next[1] = cfg_data;
                KEY_IDX_TWO:   key_next[2] = cfg_data;
                KEY_IDX_THREE: key_next[3] = cfg_data;
                default:       key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    assign key = key_reg;

endmodule

// ===== hw/rtl/xtea_round.sv =====
// ----------------------------------------------------------------------------
// XTEA half-round stage
// One Feistel half-round followed by the stage register; direction per word.
// ----------------------------------------------------------------------------
module xtea_round #(
    parameter int STAGE_IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  xtea_pkg::key_t   key,
    input  logic             in_vld,
    input  xtea_pkg::blk_t   in_blk,
    output logic             out_vld,
    output xtea_pkg::blk_t   out_blk
);
    import xtea_pkg::*;

    localparam logic [31:0] ENC_SUM = half_sum(STAGE_IDX, OP_ENCRYPT);
    localparam logic [31:0] DEC_SUM = half_sum(STAGE_IDX, OP_DECRYPT);
    localparam logic        ODD     = STAGE_IDX % 2 == 1;

    logic        dec;
    logic        upd_y;
    logic [31:0] sum;
    logic [31:0] x;
    logic [31:0] tgt;
    logic [1:0]  sel;
    logic [31:0] f;
    logic [31:0] mix;
    logic [31:0] res;
    logic        vld_reg;
    logic        vld_next;
    blk_t        blk_reg;
    blk_t        blk_next;

    always_comb begin
        dec   = (in_blk.op == OP_DECRYPT);
        // encrypt updates y on even stages, decrypt on odd ones
        upd_y = ODD ^ ~dec;
        sum   = dec ? DEC_SUM : ENC_SUM;
        x     = upd_y ? in_blk.z : in_blk.y;
        tgt   = upd_y ? in_blk.y : in_blk.z;
        sel   = upd_y ? sum[1:0] : sum[Z_SEL_LSB+1:Z_SEL_LSB];
        f     = ((x << SHL_AMT) ^ (x >> SHR_AMT)) + x;
        mix   = f ^ (sum + key[sel]);
        res   = dec ? (tgt - mix) : (tgt + mix);

        blk_next = in_blk;
        if (upd_y) begin
            blk_next.y = res;
        end else begin
            blk_next.z = res;
        end
        vld_next = in_vld;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            blk_reg <= blk_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_blk = blk_reg;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XTEA block cipher core testbench
// Streams 64-bit blocks through the core under a series of 128-bit keys and
// checks each result word against a local XTEA encrypt/decrypt calculation,
// with random stalls on both channels and a stall-free window.
// ----------------------------------------------------------------------------
module testbench;
    import xtea_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_TICKS = 10;
    localparam int IDLE_PCT    = 28;
    localparam int DRAIN_TICKS = 80;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_ERRS  = 10;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
    } cipher_words_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = KEY_IDX_ZERO;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op = OP_ENCRYPT;
    logic [31:0] s_block_first = '0;
    logic [31:0] s_block_second = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_out_first;
    logic [31:0] m_out_second;

    key_t          key_words = '0;
    blk_t          source_blocks[$];
    cipher_words_t transformed_blocks[$];
    blk_t          next_block;
    cipher_words_t want;
    int            words_queued = 0;
    int            words_sent = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    logic          quiet_window;

    xtea_block_cipher_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_block_first (s_block_first),
        .s_block_second(s_block_second),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_first   (m_out_first),
        .m_out_second  (m_out_second)
    );

    // no stalls on either side while this window of words goes through
    assign quiet_window = (words_sent >= 900) && (words_sent < 1200);

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    function automatic logic [31:0] feistel_mix(input logic [31:0] x, input logic [31:0] s,
                                                input logic [31:0] k);
        logic [31:0] f;
        f = ((x << SHL_AMT) ^ (x >> SHR_AMT)) + x;
        return f ^ (s + k);
    endfunction

    function automatic cipher_words_t xtea_transform(input logic op, input logic [31:0] y_in,
                                                     input logic [31:0] z_in);
        logic [31:0]   y;
        logic [31:0]   z;
        logic [31:0]   s;
        cipher_words_t r;
        y = y_in;
        z = z_in;
        if (op == OP_ENCRYPT) begin
            s = '0;
            for (int i = 0; i < CYCLES; i++) begin
                y = y + feistel_mix(z, s, key_words[s[1:0]]);
                s = s + DELTA;
                z = z + feistel_mix(y, s, key_words[s[Z_SEL_LSB +: 2]]);
            end
        end else begin
            s = DEC_SUM_INIT;
            for (int i = 0; i < CYCLES; i++) begin
                z = z - feistel_mix(y, s, key_words[s[Z_SEL_LSB +: 2]]);
                s = s - DELTA;
                y = y - feistel_mix(z, s, key_words[s[1:0]]);
            end
        end
        r.first  = y;
        r.second = z;
        return r;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(19))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_block(input logic op, input logic [31:0] y, input logic [31:0] z);
        blk_t b;
        b.op = op;
        b.y  = y;
        b.z  = z;
        source_blocks.push_back(b);
        words_queued++;
    endtask

    task automatic queue_random_blocks(input int count);
        logic          op;
        logic [31:0]   y;
        logic [31:0]   z;
        cipher_words_t back;
        for (int n = 0; n < count; n++) begin
            op = 1'($urandom_range(1));
            y  = random_word();
            z  = random_word();
            queue_block(op, y, z);
            // follow some words with the opposite direction on their result
            if ($urandom_range(99) < 30) begin
                back = xtea_transform(op, y, z);
                queue_block(~op, back.first, back.second);
                n++;
            end
        end
    endtask

    task automatic write_key_word(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        key_words[idx] = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        write_key_word(KEY_IDX_ZERO, k0);
        write_key_word(KEY_IDX_ONE, k1);
        write_key_word(KEY_IDX_TWO, k2);
        write_key_word(KEY_IDX_THREE, k3);
    endtask

    // hold until every queued word went in and every result came back
    task automatic wait_drained();
        do @(posedge aclk);
        while (words_sent != words_queued || transformed_blocks.size() != 0);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                transformed_blocks.push_back(xtea_transform(s_op, s_block_first,
                                                            s_block_second));
                words_sent <= words_sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (source_blocks.size() != 0 &&
                    (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
                    next_block = source_blocks.pop_front();
                    s_valid        <= 1'b1;
                    s_op           <= next_block.op;
                    s_block_first  <= next_block.y;
                    s_block_second <= next_block.z;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (transformed_blocks.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= SHOWN_ERRS)
                        $display("unexpected result word: first=%h second=%h",
                                 m_out_first, m_out_second);
                end else begin
                    want = transformed_blocks.pop_front();
                    if (m_out_first !== want.first || m_out_second !== want.second) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= SHOWN_ERRS)
                            $display("result mismatch: first exp=%h got=%h, second exp=%h got=%h",
                                     want.first, m_out_first, want.second, m_out_second);
                    end
                end
            end
            m_ready <= quiet_window || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (RESET_TICKS) @(posedge aclk);
        aresetn <= 1'b1;

        // reset key of all zeros
        queue_block(OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        queue_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();

        load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        queue_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        queue_block(OP_ENCRYPT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_block(OP_DECRYPT, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        queue_block(OP_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_block(OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0A0B, 32'h0C0D_0E0F);
        queue_block(OP_ENCRYPT, 32'h4142_4344, 32'h4546_4748);
        queue_block(OP_DECRYPT, 32'h4142_4344, 32'h4546_4748);
        queue_block(OP_ENCRYPT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_block(OP_DECRYPT, 32'hDEAD_BEEF, 32'h0123_4567);
        wait_drained();

        load_key($urandom(), $urandom(), $urandom(), $urandom());
        queue_random_blocks(300);
        wait_drained();

        load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_random_blocks(300);
        wait_drained();

        // sender pauses mid-key until the pipeline empties
        load_key($urandom(), $urandom(), $urandom(), $urandom());
        queue_random_blocks(150);
        wait_drained();
        queue_random_blocks(150);
        wait_drained();

        load_key(32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
        queue_random_blocks(300);
        wait_drained();

        load_key(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_random_blocks(250);
        wait_drained();

        load_key($urandom(), $urandom(), $urandom(), $urandom());
        queue_random_blocks(330);
        wait_drained();

        repeat (DRAIN_TICKS) @(posedge aclk);
        if (mismatches == 0 && transformed_blocks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
